// ----- rtl/core/lsf_pkg.sv -----
package lsf_pkg;

  localparam int MOTORS_DEF     = 4;
  localparam int COS_DEPTH_DEF  = 256;
  localparam int MOTORS_MAX     = 4;

  localparam int POS_W          = 28;
  localparam int VEL_W          = 17;
  localparam int TGT_W          = 28;
  localparam int DRIVE_W        = 15;
  localparam int GAIN_W         = 32;
  localparam int Q824_W         = 24;
  localparam int TOL_W          = 27;
  localparam int MECH_W         = 2;
  localparam int CFG_AW         = 3;
  localparam int CFG_DW         = 32;
  localparam int IN_DATA_W      = 208;
  localparam int OUT_DATA_W     = 24;

  localparam int VELA_W         = 20;
  localparam int ERR_W          = POS_W + 1;
  localparam int COS_W          = 17;
  localparam int FB_W           = 63;
  localparam int FF_W           = 63;
  localparam int G_W            = 20;
  localparam int G_Q16          = 642908;
  localparam int LIMIT_MV       = 12000;
  localparam int SETTLE_VEL     = 640;

  // pipeline stage numbers
  localparam int ST_SUM   = 1;
  localparam int ST_DIV   = 2;
  localparam int ST_AVG   = 3;
  localparam int ST_MUL   = 4;
  localparam int ST_FB    = 5;
  localparam int ST_Q1    = 6;
  localparam int ST_R1    = 7;
  localparam int ST_Q2    = 8;
  localparam int ST_COS   = 9;
  localparam int ST_Z     = 10;
  localparam int ST_PP    = 11;
  localparam int ST_FF    = 12;
  localparam int ST_OUT   = 13;
  localparam int NSTAGE   = 13;

  typedef logic [NSTAGE:1] stage_en_t;

  typedef enum logic [MECH_W-1:0] {
    MECH_CASCADE,
    MECH_FOUR_BAR,
    MECH_SIX_BAR,
    MECH_VIRTUAL
  } mech_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_MECH,
    CFG_K_POS,
    CFG_K_VEL,
    CFG_GRAV,
    CFG_MASS,
    CFG_ARM,
    CFG_GEAR,
    CFG_TOL
  } cfg_idx_t;

  typedef struct packed {
    mech_t                     mech;
    logic signed [GAIN_W-1:0]  k_pos;
    logic signed [GAIN_W-1:0]  k_vel;
    logic signed [GAIN_W-1:0]  grav;
    logic [Q824_W-1:0]         mass;
    logic [Q824_W-1:0]         arm;
    logic [Q824_W-1:0]         gear;
    logic [TOL_W-1:0]          tol;
  } cfg_t;

  // cos(pi/2*k/2^lg) in Q1.16, from a Q30 Taylor series up to the x^16 term
  function automatic logic [COS_W-1:0] quarter_cos(input int k, input int lg);
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint r;
    int     n;
    if (k >= (1 << lg)) begin
      return '0;
    end
    x    = (64'sd1686629713 * longint'(k)) >>> lg;
    x2   = x * x / 64'sd1073741824;
    term = 64'sd1073741824;
    sum  = 64'sd1073741824;
    for (n = 1; n <= 8; n++) begin
      term = term * x2 / 64'sd1073741824;
      unique case (n)
        1:       term = term / 64'sd2;
        2:       term = term / 64'sd12;
        3:       term = term / 64'sd30;
        4:       term = term / 64'sd56;
        5:       term = term / 64'sd90;
        6:       term = term / 64'sd132;
        7:       term = term / 64'sd182;
        default: term = term / 64'sd240;
      endcase
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum < 0) sum = 0;
    if (sum > 64'sd1073741824) sum = 64'sd1073741824;
    r = (sum + 64'sd8192) >>> 14;
    return COS_W'(r);
  endfunction

endpackage

// ----- rtl/core/lsf_avg.sv -----
module lsf_avg import lsf_pkg::*; #(
  parameter int MOTORS = MOTORS_DEF
) (
  input  logic                     clk,
  input  stage_en_t                en,
  input  logic [IN_DATA_W-1:0]     in_data,
  output logic signed [POS_W-1:0]  pos_o,
  output logic signed [VELA_W-1:0] vel_o,
  output logic signed [ERR_W-1:0]  err_o
);

  localparam int PSW = POS_W + 2;
  localparam int VSW = VEL_W + 5;
  localparam int RS  = 34;
  localparam longint unsigned RECIP_L = ((64'd1 << RS) + longint'(MOTORS) - 1) / MOTORS;
  localparam logic [RS:0] RECIP = RECIP_L[RS:0];
  localparam int VOFS = MOTORS_MAX * POS_W;
  localparam int TOFS = VOFS + MOTORS_MAX * VEL_W;

  logic signed [PSW-1:0]   psum_nxt, psum_r;
  logic signed [VSW-1:0]   vsum_nxt, vs6_r;
  logic signed [TGT_W-1:0] tgt1_r, tgt2_r;
  logic [PSW-1:0]          pa, pq_r;
  logic [VSW-1:0]          va, vq_r;
  logic                    psgn_r, vsgn_r;
  logic [PSW+RS:0]         pprod;
  logic [VSW+RS:0]         vprod;
  logic signed [POS_W-1:0] pos_nxt;

  always_comb begin
    psum_nxt = '0;
    vsum_nxt = '0;
    for (int m = 0; m < MOTORS; m++) begin
      psum_nxt = psum_nxt + PSW'($signed(in_data[m*POS_W +: POS_W]));
      vsum_nxt = vsum_nxt + VSW'($signed(in_data[VOFS + m*VEL_W +: VEL_W]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      psum_r <= psum_nxt;
      vs6_r  <= vsum_nxt * VSW'(6);
      tgt1_r <= $signed(in_data[TOFS +: TGT_W]);
    end
  end

  // magnitude times reciprocal, exact for these ranges
  assign pa    = psum_r[PSW-1] ? PSW'(-psum_r) : PSW'(psum_r);
  assign va    = vs6_r[VSW-1]  ? VSW'(-vs6_r)  : VSW'(vs6_r);
  assign pprod = (PSW+RS+1)'(pa) * (PSW+RS+1)'(RECIP);
  assign vprod = (VSW+RS+1)'(va) * (VSW+RS+1)'(RECIP);

  always_ff @(posedge clk) begin
    if (en[ST_DIV]) begin
      pq_r   <= PSW'(pprod >> RS);
      vq_r   <= VSW'(vprod >> RS);
      psgn_r <= psum_r[PSW-1];
      vsgn_r <= vs6_r[VSW-1];
      tgt2_r <= tgt1_r;
    end
  end

  assign pos_nxt = psgn_r ? POS_W'(-pq_r) : POS_W'(pq_r);

  always_ff @(posedge clk) begin
    if (en[ST_AVG]) begin
      pos_o <= pos_nxt;
      vel_o <= vsgn_r ? VELA_W'(-vq_r) : VELA_W'(vq_r);
      err_o <= ERR_W'(pos_nxt) - ERR_W'(tgt2_r);
    end
  end

endmodule

// ----- rtl/core/lsf_angle.sv -----
module lsf_angle import lsf_pkg::*; #(
  parameter int COS_TABLE_DEPTH = COS_DEPTH_DEF
) (
  input  logic                    clk,
  input  stage_en_t               en,
  input  logic [Q824_W-1:0]       gear,
  input  logic signed [POS_W-1:0] pos,
  output logic [COS_W-1:0]        cmag_o,
  output logic [1:0]              quad_o
);

  localparam int L   = $clog2(COS_TABLE_DEPTH);
  localparam int TW  = POS_W + Q824_W + 1;
  localparam int SH  = 24 - L;
  localparam int AW  = 35 + L;
  localparam int AHW = AW - 21;
  localparam longint CADD = 64'sd90 <<< (28 + L);
  localparam int S1  = AHW + 14;
  localparam int S2  = 42;
  localparam longint unsigned R1 = ((64'd1 << S1) + 64'd89) / 64'd90;
  localparam longint unsigned R2 = ((64'd1 << S2) + 64'd89) / 64'd90;

  logic signed [TW-1:0]    t_r;
  logic [AW-1:0]           a_r;
  logic [AHW-1:0]          ah_r, q1_r;
  logic [20:0]             al6_r, al7_r;
  logic [6:0]              r1_r;
  logic [L+1:0]            idx_r;
  logic [63:0]             p1, p2;
  logic [AHW-1:0]          rem;
  logic [L:0]              sel;
  logic [COS_W-1:0]        cos_tab [0:COS_TABLE_DEPTH];

  for (genvar g = 0; g <= COS_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [COS_W-1:0] CV = quarter_cos(g, L);
    assign cos_tab[g] = CV;
  end

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      t_r <= TW'(pos) * TW'($signed({1'b0, gear}));
    end
  end

  // offset by a whole number of turns so the value is never negative
  always_ff @(posedge clk) begin
    if (en[ST_FB]) begin
      a_r <= AW'(64'(t_r >>> SH) + CADD);
    end
  end

  assign p1 = 64'(a_r[AW-1:21]) * R1;

  always_ff @(posedge clk) begin
    if (en[ST_Q1]) begin
      q1_r  <= AHW'(p1 >> S1);
      ah_r  <= a_r[AW-1:21];
      al6_r <= a_r[20:0];
    end
  end

  assign rem = ah_r - AHW'(q1_r * AHW'(90));

  always_ff @(posedge clk) begin
    if (en[ST_R1]) begin
      r1_r  <= rem[6:0];
      al7_r <= al6_r;
    end
  end

  assign p2 = 64'({r1_r, al7_r}) * R2;

  always_ff @(posedge clk) begin
    if (en[ST_Q2]) begin
      idx_r <= p2[S2 +: L+2];
    end
  end

  assign sel = (idx_r[L] == 1'b0) ? {1'b0, idx_r[L-1:0]}
                                  : (L+1)'(COS_TABLE_DEPTH) - (L+1)'(idx_r[L-1:0]);

  always_ff @(posedge clk) begin
    if (en[ST_COS]) begin
      cmag_o <= cos_tab[sel];
      quad_o <= idx_r[L+1:L];
    end
  end

endmodule

// ----- rtl/core/lsf_ffwd.sv -----
module lsf_ffwd import lsf_pkg::*; (
  input  logic                   clk,
  input  stage_en_t              en,
  input  cfg_t                   cfg,
  input  logic [COS_W-1:0]       cmag,
  input  logic [1:0]             quad,
  output logic signed [FF_W-1:0] ff_o
);

  localparam int GMW = GAIN_W + Q824_W;
  localparam int XW  = GMW + G_W;
  localparam int ZW  = 41;
  localparam int XC  = 26;
  localparam int ZC  = 21;
  localparam int PPW = XC + ZC;
  localparam int YW  = XW + ZW;

  logic [GAIN_W-1:0] ggm;
  logic [GMW-1:0]    gm_r;
  logic [47:0]       xp0_r, xp1_r;
  logic [XW-1:0]     x_r [ST_Q1:ST_Z];
  logic [ZW-1:0]     z_r;
  logic              neg10_r, neg11_r;
  logic [PPW-1:0]    pp_r [0:2][0:1];
  logic [XC-1:0]     xch [0:2];
  logic [ZC-1:0]     zch [0:1];
  logic [YW-1:0]     ysum;
  logic [60:0]       mag;

  assign ggm = cfg.grav[GAIN_W-1] ? GAIN_W'(-cfg.grav) : GAIN_W'(cfg.grav);

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) gm_r <= GMW'(ggm) * GMW'(cfg.mass);
    if (en[ST_FB]) begin
      xp0_r <= 48'(gm_r[27:0]) * 48'(G_Q16);
      xp1_r <= 48'(gm_r[55:28]) * 48'(G_Q16);
    end
    if (en[ST_Q1]) x_r[ST_Q1] <= XW'(xp0_r) + (XW'(xp1_r) << 28);
    for (int s = ST_R1; s <= ST_Z; s++) begin
      if (en[s]) x_r[s] <= x_r[s-1];
    end
  end

  // cascade: scale by 2^32 so one shift serves both cases
  always_ff @(posedge clk) begin
    if (en[ST_Z]) begin
      if (cfg.mech == MECH_CASCADE) begin
        z_r     <= ZW'(64'd1 << 32);
        neg10_r <= cfg.grav[GAIN_W-1];
      end else begin
        z_r     <= ZW'(cfg.arm) * ZW'(cmag);
        neg10_r <= cfg.grav[GAIN_W-1] ^ (quad == 2'd1 || quad == 2'd2);
      end
    end
  end

  assign xch[0] = x_r[ST_Z][25:0];
  assign xch[1] = x_r[ST_Z][51:26];
  assign xch[2] = XC'(x_r[ST_Z][XW-1:52]);
  assign zch[0] = z_r[20:0];
  assign zch[1] = ZC'(z_r[ZW-1:21]);

  always_ff @(posedge clk) begin
    if (en[ST_PP]) begin
      neg11_r <= neg10_r;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 2; j++) begin
          pp_r[i][j] <= PPW'(xch[i]) * PPW'(zch[j]);
        end
      end
    end
  end

  always_comb begin
    ysum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 2; j++) begin
        ysum = ysum + (YW'(pp_r[i][j]) << (XC*i + ZC*j));
      end
    end
  end

  assign mag = ysum[YW-1:56];

  always_ff @(posedge clk) begin
    if (en[ST_FF]) begin
      ff_o <= neg11_r ? -FF_W'(mag) : FF_W'(mag);
    end
  end

endmodule

// ----- rtl/core/lift_state_feedback_with_gravity_ff.sv -----
// Lift controller: each item carries the motor encoder positions and velocities
// and the target; the block averages the first MOTORS motors, applies the
// position and velocity gains, adds gravity feedforward (constant for a cascade,
// cosine of the lift angle for the linkages) and returns the drive in mV clamped
// to +-12000 with settled and clamped flags. One item per cycle is accepted
// unless back-pressure stalls a full pipeline; each result passes the 13-stage
// pipeline whose first stage takes the item at the accepting edge (averaging
// divide, gain multipliers, angle reduction, cosine table and the split wide
// feedforward product). Empty stages close up under back-pressure. The user must
// write configuration via cfg_we/cfg_addr/cfg_wdata while idle (not enforced).
module lift_state_feedback_with_gravity_ff import lsf_pkg::*; #(
  parameter int MOTORS          = MOTORS_DEF,
  parameter int COS_TABLE_DEPTH = COS_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_AW-1:0]     cfg_addr,
  input  logic [CFG_DW-1:0]     cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pos_0..pos_3, vel_0..vel_3, target
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // drive_mv, settled, clamped, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam logic signed [63:0] LIM = 64'sd12000 <<< 24;

  cfg_t                     cfg_r;
  stage_en_t                en;
  logic [NSTAGE:1]          v_r;
  logic signed [POS_W-1:0]  pos3;
  logic signed [VELA_W-1:0] vel3;
  logic signed [ERR_W-1:0]  err3;
  logic [COS_W-1:0]         cmag9;
  logic [1:0]               quad9;
  logic signed [FF_W-1:0]   ff12;
  logic signed [60:0]       pp_r;
  logic signed [51:0]       pv_r;
  logic signed [FB_W-1:0]   fb_r [ST_FB:ST_FF];
  logic                     set_r [ST_MUL:ST_FF];
  logic [ERR_W-1:0]         err_abs;
  logic [VELA_W-1:0]        vel_abs;
  logic signed [63:0]       total;
  logic signed [63:0]       tr;
  logic signed [DRIVE_W-1:0] drive_nxt, drive_r;
  logic                     clamp_nxt, clamp_r, settled_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mech  <= MECH_CASCADE;
      cfg_r.k_pos <= '0;
      cfg_r.k_vel <= '0;
      cfg_r.grav  <= '0;
      cfg_r.mass  <= '0;
      cfg_r.arm   <= Q824_W'(65536);
      cfg_r.gear  <= Q824_W'(65536);
      cfg_r.tol   <= TOL_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_MECH:  cfg_r.mech  <= mech_t'(cfg_wdata[MECH_W-1:0]);
        CFG_K_POS: cfg_r.k_pos <= cfg_wdata;
        CFG_K_VEL: cfg_r.k_vel <= cfg_wdata;
        CFG_GRAV:  cfg_r.grav  <= cfg_wdata;
        CFG_MASS:  cfg_r.mass  <= cfg_wdata[Q824_W-1:0];
        CFG_ARM:   cfg_r.arm   <= cfg_wdata[Q824_W-1:0];
        CFG_GEAR:  cfg_r.gear  <= cfg_wdata[Q824_W-1:0];
        CFG_TOL:   cfg_r.tol   <= cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage moves when it is empty or the next one moves
  always_comb begin
    en[NSTAGE] = !v_r[NSTAGE] || out_tready;
    for (int s = NSTAGE - 1; s >= 1; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  assign in_tready = en[ST_SUM];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_tvalid;
      for (int s = 2; s <= NSTAGE; s++) begin
        if (en[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  lsf_avg #(.MOTORS(MOTORS)) u_avg (
    .clk(clk), .en(en), .in_data(in_tdata), .pos_o(pos3), .vel_o(vel3), .err_o(err3)
  );

  lsf_angle #(.COS_TABLE_DEPTH(COS_TABLE_DEPTH)) u_angle (
    .clk(clk), .en(en), .gear(cfg_r.gear), .pos(pos3), .cmag_o(cmag9), .quad_o(quad9)
  );

  lsf_ffwd u_ffwd (
    .clk(clk), .en(en), .cfg(cfg_r), .cmag(cmag9), .quad(quad9), .ff_o(ff12)
  );

  assign err_abs = err3[ERR_W-1] ? ERR_W'(-err3) : ERR_W'(err3);
  assign vel_abs = vel3[VELA_W-1] ? VELA_W'(-vel3) : VELA_W'(vel3);

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      pp_r          <= 61'(cfg_r.k_pos) * 61'(err3);
      pv_r          <= 52'(cfg_r.k_vel) * 52'(vel3);
      set_r[ST_MUL] <= (err_abs < ERR_W'(cfg_r.tol)) && (vel_abs < VELA_W'(SETTLE_VEL));
    end
    if (en[ST_FB]) begin
      fb_r[ST_FB]  <= FB_W'(pp_r) + (FB_W'(pv_r) <<< 2);
      set_r[ST_FB] <= set_r[ST_MUL];
    end
    for (int s = ST_Q1; s <= ST_FF; s++) begin
      if (en[s]) begin
        fb_r[s]  <= fb_r[s-1];
        set_r[s] <= set_r[s-1];
      end
    end
  end

  assign total = 64'(ff12) - 64'(fb_r[ST_FF]);
  assign tr    = (total + (total[63] ? 64'sd16777215 : 64'sd0)) >>> 24;

  always_comb begin
    clamp_nxt = 1'b1;
    priority if (total > LIM) begin
      drive_nxt = DRIVE_W'(LIMIT_MV);
    end else if (total < -LIM) begin
      drive_nxt = -DRIVE_W'(LIMIT_MV);
    end else begin
      drive_nxt = DRIVE_W'(tr);
      clamp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      drive_r   <= drive_nxt;
      clamp_r   <= clamp_nxt;
      settled_r <= set_r[ST_FF];
    end
  end

  assign out_tvalid = v_r[ST_OUT];
  assign out_tdata  = {(OUT_DATA_W-DRIVE_W-2)'(0), clamp_r, settled_r, drive_r};

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  a_clamp_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && clamp_r |-> drive_r == 15'sd12000 || drive_r == -15'sd12000)
    else $error("clamped drive not at the limit");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !clamp_r |-> drive_r <= 15'sd12000 && drive_r >= -15'sd12000)
    else $error("unclamped drive outside the limit");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && !in_tready |=> $stable(v_r))
    else $error("pipeline moved while fully stalled");

endmodule

// ----- tb/tb_lift_state_feedback_with_gravity_ff.sv -----
`timescale 1ns / 100ps

module tb_lift_state_feedback_with_gravity_ff;
  import lsf_pkg::*;

  typedef struct {
    logic signed [POS_W-1:0] pos [4];
    logic signed [VEL_W-1:0] vel [4];
    logic signed [TGT_W-1:0] tgt;
  } tick_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic                      settled;
    logic                      clamped;
  } drive_t;

  typedef struct {
    tick_t  t;
    logic   known;
    drive_t res;
  } row_t;

  localparam longint ONE_Q30  = 64'sd1073741824;
  localparam longint TURN     = 64'sd360 <<< 24;
  localparam longint LIM      = 64'sd12000 <<< 24;
  localparam int     RAND_PER = 65;
  localparam int     WD_LIMIT = 3000;
  localparam int     HOLD_LEN = 150;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // shadow registers
  mech_t                    mech_r;
  logic signed [GAIN_W-1:0] kpos_r, kvel_r, grav_r;
  logic [Q824_W-1:0]        mass_r, arm_r, gear_r;
  logic [TOL_W-1:0]         tol_r;

  drive_t drive_q[$];
  row_t   dir_tab[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     quiet = 0;
  int     hold_reqs = 0;
  int     hold_seen = 0;
  int     hold_left = 0;
  int     stall_left = 0;

  lift_state_feedback_with_gravity_ff dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint cos_q16(longint k);
    longint ang, sq, term, acc;
    int n;
    if (k >= COS_DEPTH_DEF) return 0;
    ang = 64'sd1686629713 * k / COS_DEPTH_DEF;
    sq = ang * ang / ONE_Q30;
    term = ONE_Q30;
    acc = ONE_Q30;
    for (n = 1; n <= 8; n++) begin
      term = term * sq / ONE_Q30;
      term = term / ((2 * n - 1) * (2 * n));
      if (n % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    if (acc < 0) acc = 0;
    if (acc > ONE_Q30) acc = ONE_Q30;
    return (acc + 64'sd8192) >>> 14;
  endfunction

  function automatic drive_t predict_drive(tick_t t);
    longint psum, vsum, pos, vel, err, fb, ff, total, r, idx, q, k, cm;
    logic [127:0] prod, mag;
    logic neg;
    int i, sh;
    drive_t d;
    psum = 0;
    vsum = 0;
    for (i = 0; i < MOTORS_DEF; i++) begin
      psum += longint'(t.pos[i]);
      vsum += longint'(t.vel[i]);
    end
    pos = psum / MOTORS_DEF;
    vel = (vsum * 6) / MOTORS_DEF;
    err = pos - longint'(t.tgt);
    fb = longint'(kpos_r) * err + longint'(kvel_r) * vel * 4;
    neg = grav_r[GAIN_W-1];
    prod = 128'(neg ? -longint'(grav_r) : longint'(grav_r));
    prod = prod * 128'(mass_r) * 128'(G_Q16);
    sh = 24;
    if (mech_r != MECH_CASCADE) begin
      r = (pos * longint'(gear_r)) % TURN;
      if (r < 0) r += TURN;
      idx = r * 4 * COS_DEPTH_DEF / TURN;
      q = idx / COS_DEPTH_DEF;
      k = idx % COS_DEPTH_DEF;
      cm = (q == 0 || q == 2) ? cos_q16(k) : cos_q16(COS_DEPTH_DEF - k);
      if (q == 1 || q == 2) neg = ~neg;
      prod = prod * 128'(arm_r) * 128'(cm);
      sh = 56;
    end
    mag = prod >> sh;
    if (mag > (128'd1 << 61)) mag = 128'd1 << 61;
    ff = neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    total = ff - fb;
    d.clamped = 1'b1;
    if (total > LIM) d.drive = 15'sd12000;
    else if (total < -LIM) d.drive = -15'sd12000;
    else begin
      d.drive = DRIVE_W'(total / 64'sd16777216);
      d.clamped = 1'b0;
    end
    d.settled = ((err < 0 ? -err : err) < longint'(tol_r)) &&
                ((vel < 0 ? -vel : vel) < SETTLE_VEL);
    return d;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_tick(tick_t t);
    return {t.tgt, t.vel[3], t.vel[2], t.vel[1], t.vel[0],
            t.pos[3], t.pos[2], t.pos[1], t.pos[0]};
  endfunction

  function automatic tick_t uniform_tick(longint p, longint v, longint tg);
    tick_t t;
    int i;
    for (i = 0; i < 4; i++) begin
      t.pos[i] = POS_W'(p);
      t.vel[i] = VEL_W'(v);
    end
    t.tgt = TGT_W'(tg);
    return t;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    longint base;
    int i, mode;
    mode = $urandom_range(0, 3);
    base = longint'($signed(POS_W'($urandom)));
    t.tgt = TGT_W'(base);
    for (i = 0; i < 4; i++) begin
      case (mode)
        0: begin
          t.pos[i] = POS_W'($urandom);
          t.vel[i] = VEL_W'($urandom);
          t.tgt = TGT_W'($urandom);
        end
        1: begin
          t.pos[i] = POS_W'(base + $signed($urandom_range(0, 600)) - 300);
          t.vel[i] = VEL_W'($signed($urandom_range(0, 240)) - 120);
        end
        default: begin
          t.pos[i] = POS_W'($signed($urandom_range(0, 131072)) - 65536);
          t.vel[i] = VEL_W'($signed($urandom_range(0, 4000)) - 2000);
          t.tgt = TGT_W'($signed($urandom_range(0, 131072)) - 65536);
        end
      endcase
    end
    return t;
  endfunction

  function automatic logic [31:0] small_gain();
    return 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
  endfunction

  task automatic write_reg(cfg_idx_t a, logic [31:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = a;
    cfg_wdata = v;
    case (a)
      CFG_MECH:  mech_r = mech_t'(v[MECH_W-1:0]);
      CFG_K_POS: kpos_r = v;
      CFG_K_VEL: kvel_r = v;
      CFG_GRAV:  grav_r = v;
      CFG_MASS:  mass_r = v[Q824_W-1:0];
      CFG_ARM:   arm_r = v[Q824_W-1:0];
      CFG_GEAR:  gear_r = v[Q824_W-1:0];
      default:   tol_r = v[TOL_W-1:0];
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // upper bits are junk on purpose; the block must drop them
  task automatic load_regs(logic [31:0] m, logic [31:0] kp, logic [31:0] kv,
                           logic [31:0] gg, logic [31:0] ms, logic [31:0] ar,
                           logic [31:0] gr, logic [31:0] tl);
    write_reg(CFG_MECH, {$urandom} << MECH_W | m);
    write_reg(CFG_K_POS, kp);
    write_reg(CFG_K_VEL, kv);
    write_reg(CFG_GRAV, gg);
    write_reg(CFG_MASS, {$urandom} << Q824_W | ms);
    write_reg(CFG_ARM, {$urandom} << Q824_W | ar);
    write_reg(CFG_GEAR, {$urandom} << Q824_W | gr);
    write_reg(CFG_TOL, {$urandom} << TOL_W | tl);
  endtask

  task automatic send_tick(tick_t t, logic known, drive_t res);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      n = $urandom_range(1, 7);
      repeat (n) @(negedge clk);
    end
    in_tdata = pack_tick(t);
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    drive_q.push_back(known ? res : predict_drive(t));
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (NSTAGE + 6) @(posedge clk);
  endtask

  function automatic row_t mk_row(tick_t t, logic known, logic s);
    row_t r;
    r.t = t;
    r.known = known;
    r.res.drive = '0;
    r.res.settled = s;
    r.res.clamped = 1'b0;
    return r;
  endfunction

  // receiver
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    drive_t e;
    drive_t a;
    if (rst_n && out_tvalid && out_tready) begin
      a.drive = out_tdata[DRIVE_W-1:0];
      a.settled = out_tdata[DRIVE_W];
      a.clamped = out_tdata[DRIVE_W+1];
      if (drive_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item drive=%0d", $time, a.drive);
      end else begin
        e = drive_q.pop_front();
        if (a.drive !== e.drive) begin
          errors++;
          $display("%0t: drive_mv exp %0d got %0d", $time, e.drive, a.drive);
        end
        if (a.settled !== e.settled) begin
          errors++;
          $display("%0t: settled exp %0b got %0b", $time, e.settled, a.settled);
        end
        if (a.clamped !== e.clamped) begin
          errors++;
          $display("%0t: clamped exp %0b got %0b", $time, e.clamped, a.clamped);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int ph, i;
    drive_t none;
    none = '{default: '0};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    mech_r = MECH_CASCADE;
    kpos_r = '0;
    kvel_r = '0;
    grav_r = '0;
    mass_r = '0;
    arm_r = 24'd65536;
    gear_r = 24'd65536;
    tol_r = 27'd256;

    // drive is zero at reset settings; only the settled flag varies
    dir_tab.push_back(mk_row(uniform_tick(0, 0, 0), 1, 1));
    dir_tab.push_back(mk_row(uniform_tick(134217727, 0, 134217727), 1, 1));
    dir_tab.push_back(mk_row(uniform_tick(-134217728, 0, 134217727), 1, 0));
    dir_tab.push_back(mk_row(uniform_tick(134217727, 0, -134217728), 1, 0));
    dir_tab.push_back(mk_row(uniform_tick(0, 65535, 0), 1, 0));
    dir_tab.push_back(mk_row(uniform_tick(0, -65536, -134217728), 1, 0));
    dir_tab.push_back(mk_row(uniform_tick(255, 0, 0), 1, 1));
    dir_tab.push_back(mk_row(uniform_tick(256, 0, 0), 1, 0));
    dir_tab.push_back(mk_row(uniform_tick(0, 106, 0), 1, 1));
    dir_tab.push_back(mk_row(uniform_tick(0, -107, 0), 1, 0));
    dir_tab.push_back(mk_row(uniform_tick(-255, -106, 0), 1, 1));
    dir_tab.push_back(mk_row(uniform_tick(46080, 0, 0), 1, 0));
    dir_tab.push_back(mk_row(uniform_tick(-46080, 1, -46080), 1, 1));
    begin
      row_t r;
      r = mk_row(uniform_tick(134217727, 1, 0), 1, 1);
      r.t.pos[1] = -134217728;
      r.t.pos[3] = -134217728;
      r.t.vel[1] = -1;
      dir_tab.push_back(r);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        1: load_regs(32'(MECH_CASCADE), 100 << 16, 1 << 16, 1 << 16, 3 << 16,
                     2 << 16, 1 << 16, 1280);
        2: load_regs(32'(MECH_FOUR_BAR), small_gain(), small_gain(), -(1 << 16),
                     5 << 16, 1 << 15, $urandom_range(0, 1 << 20),
                     $urandom_range(0, 4096));
        3: load_regs(32'(MECH_SIX_BAR), 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                     32'hffffff, 32'hffffff, 32'hffffff, 32'h7ffffff);
        4: load_regs(32'(MECH_VIRTUAL), 32'h80000000, 32'h7fffffff, 32'h80000000,
                     32'h0, 32'h0, 32'h0, 32'h0);
        5: load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
        6: begin
          load_regs($urandom, small_gain(), small_gain(), small_gain(),
                    $urandom_range(0, 1 << 19), $urandom_range(0, 1 << 18),
                    $urandom_range(0, 1 << 18), $urandom_range(0, 8192));
          quiet = 1;
        end
        default: ;
      endcase
      if (ph == 0 || ph == 3)
        foreach (dir_tab[j])
          send_tick(dir_tab[j].t, dir_tab[j].known && ph == 0, dir_tab[j].res);
      for (i = 0; i < RAND_PER; i++) begin
        if (ph == 2 && i == 10) hold_reqs++;
        send_tick(random_tick(), 1'b0, none);
      end
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/lsf_pkg.sv
rtl/core/lsf_avg.sv
rtl/core/lsf_angle.sv
rtl/core/lsf_ffwd.sv
rtl/core/lift_state_feedback_with_gravity_ff.sv
tb/tb_lift_state_feedback_with_gravity_ff.sv
